// ----- hw/rtl/range_scan_projection_core_assert.svh -----
// assertion macros for the range scan projection core
// used by modules that check their own control logic
`ifndef RANGE_SCAN_PROJECTION_CORE_ASSERT_SVH
`define RANGE_SCAN_PROJECTION_CORE_ASSERT_SVH

// same-cycle implication
`define RSP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range scan check failed");

// next-cycle implication
`define RSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range scan check failed");

`endif

// ----- hw/rtl/rsp_pkg.sv -----
// shared types, codes and constant tables of the range scan projection core
// no dependencies
package rsp_pkg;

    localparam int COORD_W   = 24;
    localparam int ANGLE_W   = 16;
    localparam int RANGE_W   = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_POSE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd6;

    localparam logic RESULT_POINT   = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [13:0] OCTANT  = 14'd8192;
    localparam logic [14:0] QUARTER = 15'd16384;

    localparam logic [3:0] SIN_TERMS = 4'd4;
    localparam logic [3:0] NUM_TERMS = 4'd9;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               last_beam;
    } in_item_t;

    typedef struct packed {
        logic                      result_kind;
        logic signed [COORD_W-1:0] x_mm;
        logic signed [COORD_W-1:0] y_mm;
        logic                      point_kept;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } out_item_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] beam_angle;
        logic               kept;
        logic               last_beam;
        logic               first;
    } queue_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pose_heading;
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
    } scan_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_X,
        B_X2,
        B_TMUL,
        B_TDIV,
        B_TFIX,
        B_ROUND,
        B_OFF_C,
        B_OFF_S,
        B_XY,
        B_POINT,
        B_DIV_START,
        B_DIV_WAIT,
        B_SUMMARY
    } back_state_t;

    // series divisors: sin terms first, then cos terms
    function automatic logic [6:0] term_divisor(input logic [3:0] term);
        logic [6:0] d;
        case (term)
            4'd0:    d = 7'd6;
            4'd1:    d = 7'd20;
            4'd2:    d = 7'd42;
            4'd3:    d = 7'd72;
            4'd4:    d = 7'd2;
            4'd5:    d = 7'd12;
            4'd6:    d = 7'd30;
            4'd7:    d = 7'd56;
            4'd8:    d = 7'd90;
            default: d = 7'd1;
        endcase
        return d;
    endfunction

    // floor of 2^32 over the divisor
    function automatic logic [31:0] term_recip(input logic [3:0] term);
        logic [31:0] m;
        case (term)
            4'd0:    m = 32'(64'd4294967296 / 64'd6);
            4'd1:    m = 32'(64'd4294967296 / 64'd20);
            4'd2:    m = 32'(64'd4294967296 / 64'd42);
            4'd3:    m = 32'(64'd4294967296 / 64'd72);
            4'd4:    m = 32'(64'd4294967296 / 64'd2);
            4'd5:    m = 32'(64'd4294967296 / 64'd12);
            4'd6:    m = 32'(64'd4294967296 / 64'd30);
            4'd7:    m = 32'(64'd4294967296 / 64'd56);
            4'd8:    m = 32'(64'd4294967296 / 64'd90);
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/range_scan_projection_core.sv -----
// range scan projection core: polar readings to world points, box and barycenter
// per reading the back end steps through these, sharing one 32x32 multiplier for the series sin/cos
// (x, x squared, nine terms of three steps each, round, two offsets, place, emit)
// a last reading adds a summary, its barycenter from the iterative divider unless no reading was kept
// the queue takes 4 readings ahead
// reset clears registers to their defaults, the queue, the scan state and the output
// depends on rsp_pkg, rsp_fifo, rsp_front, rsp_back, rsp_div
module range_scan_projection_core #(
    parameter int MAX_READINGS = 4096,
    parameter int TRIG_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // readings in
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rsp_pkg::in_item_t                 in_item,
    // results out
    output logic                              out_valid,
    input  logic                              out_stall,
    output rsp_pkg::out_item_t                out_item,
    // register writes
    input  logic                              cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsp_pkg::CFG_W-1:0]         cfg_data
);

    localparam int QUEUE_DEPTH = 4;

    // configuration registers
    logic signed [rsp_pkg::COORD_W-1:0] pose_x_reg, pose_y_reg;
    rsp_pkg::scan_cfg_t                 scan_cfg_reg;

    // queue between front and back
    logic                 q_push, q_pop, q_full, q_empty;
    rsp_pkg::queue_item_t q_push_item, q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg                <= '0;
            pose_y_reg                <= '0;
            scan_cfg_reg.pose_heading <= '0;
            scan_cfg_reg.start_angle  <= '0;
            scan_cfg_reg.angle_step   <= '0;
            scan_cfg_reg.min_range    <= '0;
            scan_cfg_reg.max_range    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsp_pkg::REG_POSE_X:       pose_x_reg <= cfg_data;
                rsp_pkg::REG_POSE_Y:       pose_y_reg <= cfg_data;
                rsp_pkg::REG_POSE_HEADING: scan_cfg_reg.pose_heading <= cfg_data[15:0];
                rsp_pkg::REG_START_ANGLE:  scan_cfg_reg.start_angle  <= cfg_data[15:0];
                rsp_pkg::REG_ANGLE_STEP:   scan_cfg_reg.angle_step   <= cfg_data[15:0];
                rsp_pkg::REG_MIN_RANGE:    scan_cfg_reg.min_range    <= cfg_data[15:0];
                rsp_pkg::REG_MAX_RANGE:    scan_cfg_reg.max_range    <= cfg_data[15:0];
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // front: angle accumulator, scan start and range filter
    rsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .cfg        (scan_cfg_reg),
        .queue_full (q_full),
        .in_stall   (in_stall),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    // short queue so that readings keep flowing while the back end works
    rsp_fifo #(
        .WIDTH ($bits(rsp_pkg::queue_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_item),
        .pop       (q_pop),
        .pop_data  (q_pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: trig, projection, box and sums, summary
    rsp_back #(
        .TRIG_BITS    (TRIG_BITS),
        .MAX_READINGS (MAX_READINGS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .pop_item    (q_pop_item),
        .pop         (q_pop),
        .pose_x      (pose_x_reg),
        .pose_y      (pose_y_reg),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_item    (out_item)
    );

endmodule

// ----- hw/rtl/rsp_fifo.sv -----
// short register queue between front and back of the range scan core
// no dependencies
module rsp_fifo #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/rsp_front.sv -----
// front end: takes readings, tracks the beam angle and applies the range filter
// depends on rsp_pkg
module rsp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rsp_pkg::in_item_t   in_item,
    input  rsp_pkg::scan_cfg_t  cfg,
    input  logic                queue_full,
    output logic                in_stall,
    output logic                push,
    output rsp_pkg::queue_item_t push_item
);

    logic                        scan_open_reg, scan_open_next;
    logic [rsp_pkg::ANGLE_W-1:0] beam_angle_reg, beam_angle_next;
    logic [rsp_pkg::ANGLE_W-1:0] angle_cur;

    assign in_stall  = queue_full;
    assign push      = in_valid && !queue_full;
    // a new scan reloads the angle from the heading and start angle
    assign angle_cur = scan_open_reg ? beam_angle_reg : cfg.pose_heading + cfg.start_angle;

    always_comb
    begin
        push_item.range_mm   = in_item.range_mm;
        push_item.beam_angle = angle_cur;
        push_item.kept       = (in_item.range_mm >= cfg.min_range) &&
                               (in_item.range_mm <= cfg.max_range);
        push_item.last_beam  = in_item.last_beam;
        push_item.first      = !scan_open_reg;
    end

    always_comb
    begin
        scan_open_next  = scan_open_reg;
        beam_angle_next = beam_angle_reg;
        if (push)
        begin
            scan_open_next  = !in_item.last_beam;
            beam_angle_next = angle_cur + cfg.angle_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_open_reg  <= 1'b0;
            beam_angle_reg <= '0;
        end
        else
        begin
            scan_open_reg  <= scan_open_next;
            beam_angle_reg <= beam_angle_next;
        end
    end

endmodule

// ----- hw/rtl/rsp_div.sv -----
// iterative restoring divider, signed numerator, unsigned denominator
// truncates toward zero; depends on rsp_pkg
module rsp_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output rsp_pkg::div_status_t    status,
    output logic signed [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [DEN_W:0]    shifted;
    logic              ge;

    assign shifted     = {rem_reg, acc_reg[NUM_W-1]};
    assign ge          = shifted >= {1'b0, den_reg};
    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            acc_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            acc_reg <= {acc_reg[NUM_W-2:0], ge};
        end
    end

endmodule

// ----- hw/rtl/rsp_back.sv -----
// back end: series sin and cos on one shared multiplier, projection,
// box and sums, summary with barycenter; depends on rsp_pkg, rsp_div and the assertion header
`include "range_scan_projection_core_assert.svh"

module rsp_back #(
    parameter int TRIG_BITS    = 16,
    parameter int MAX_READINGS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                queue_empty,
    input  rsp_pkg::queue_item_t                pop_item,
    output logic                                pop,
    input  logic signed [rsp_pkg::COORD_W-1:0]  pose_x,
    input  logic signed [rsp_pkg::COORD_W-1:0]  pose_y,
    input  logic                                out_stall,
    output logic                                out_valid,
    output rsp_pkg::out_item_t                  out_item
);

    localparam int MAG_W = TRIG_BITS + 1;
    localparam int SUM_W = rsp_pkg::COORD_W + $clog2(MAX_READINGS);
    localparam int CNT_W = $clog2(MAX_READINGS + 1);
    localparam int OFF_W = rsp_pkg::RANGE_W + 1;
    localparam logic [31:0] ROUND_HALF = 32'd1 << (29 - TRIG_BITS);
    localparam logic [40:0] OFF_HALF   = 41'd1 << (TRIG_BITS - 1);

    rsp_pkg::back_state_t state_reg, state_next;
    rsp_pkg::queue_item_t item_reg;

    logic [31:0] x_reg, x2_reg, t_reg, p_reg, q_reg;
    logic signed [31:0] s_reg, c_reg;
    logic [3:0]  term_reg;
    logic [MAG_W-1:0] co_mag_reg, si_mag_reg;
    logic        co_neg_reg, si_neg_reg;
    logic [OFF_W-1:0] off_c_reg, off_s_reg;
    logic signed [rsp_pkg::COORD_W-1:0] x_pt_reg, y_pt_reg;
    logic signed [rsp_pkg::COORD_W-1:0] box_lx_reg, box_ly_reg, box_hx_reg, box_hy_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [CNT_W-1:0] kept_count_reg;
    logic        out_valid_reg;
    rsp_pkg::out_item_t out_item_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        out_free, out_load, div_start;
    logic        fold_swap;
    logic [14:0] fold_a;
    logic [6:0]  div_d;
    logic [31:0] qd, rdiff, qf;
    logic [31:0] cos_q, sin_q, cos_rnd, sin_rnd;
    logic [40:0] off_full;
    rsp_pkg::div_status_t div_x_status, div_y_status;
    logic signed [SUM_W-1:0] quot_x, quot_y;

    function automatic logic signed [rsp_pkg::COORD_W-1:0] place(
        input logic signed [rsp_pkg::COORD_W-1:0] base,
        input logic [OFF_W-1:0]                   off,
        input logic                               neg
    );
        logic signed [25:0] ext;
        logic signed [25:0] delta;
        logic signed [25:0] total;
        logic signed [rsp_pkg::COORD_W-1:0] res;
        ext   = 26'(base);
        delta = neg ? -$signed(26'(off)) : $signed(26'(off));
        total = ext + delta;
        if (total[25:23] == 3'b000 || total[25:23] == 3'b111)
        begin
            res = total[23:0];
        end
        else
        begin
            res = total[25] ? 24'sh800000 : 24'sh7FFFFF;
        end
        return res;
    endfunction

    // octant fold: beyond pi/4 the series runs on the complement angle
    assign fold_swap = item_reg.beam_angle[13:0] > rsp_pkg::OCTANT;
    assign fold_a    = fold_swap ? rsp_pkg::QUARTER - {1'b0, item_reg.beam_angle[13:0]}
                                 : {1'b0, item_reg.beam_angle[13:0]};

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // exact constant division: reciprocal estimate is low by at most one
    assign div_d = rsp_pkg::term_divisor(term_reg);
    assign qd    = q_reg * {25'd0, div_d};
    assign rdiff = p_reg - qd;
    assign qf    = q_reg + {31'd0, (rdiff >= {25'd0, div_d})};

    assign cos_q   = fold_swap ? s_reg : c_reg;
    assign sin_q   = fold_swap ? c_reg : s_reg;
    assign cos_rnd = (cos_q + ROUND_HALF) >> (30 - TRIG_BITS);
    assign sin_rnd = (sin_q + ROUND_HALF) >> (30 - TRIG_BITS);
    assign off_full = (prod[40:0] + OFF_HALF) >> TRIG_BITS;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rsp_pkg::B_X:
            begin
                mul_a = {17'd0, fold_a};
                mul_b = rsp_pkg::PI_Q30;
            end
            rsp_pkg::B_X2:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            rsp_pkg::B_TMUL:
            begin
                mul_a = t_reg;
                mul_b = x2_reg;
            end
            rsp_pkg::B_TDIV:
            begin
                mul_a = p_reg;
                mul_b = rsp_pkg::term_recip(term_reg);
            end
            rsp_pkg::B_OFF_C:
            begin
                mul_a = 32'(co_mag_reg);
                mul_b = 32'(item_reg.range_mm);
            end
            rsp_pkg::B_OFF_S:
            begin
                mul_a = 32'(si_mag_reg);
                mul_b = 32'(item_reg.range_mm);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsp_pkg::B_IDLE:      if (!queue_empty) state_next = rsp_pkg::B_X;
            rsp_pkg::B_X:         state_next = rsp_pkg::B_X2;
            rsp_pkg::B_X2:        state_next = rsp_pkg::B_TMUL;
            rsp_pkg::B_TMUL:      state_next = rsp_pkg::B_TDIV;
            rsp_pkg::B_TDIV:      state_next = rsp_pkg::B_TFIX;
            rsp_pkg::B_TFIX:
            begin
                state_next = (term_reg == rsp_pkg::NUM_TERMS - 1'b1) ? rsp_pkg::B_ROUND
                                                                       : rsp_pkg::B_TMUL;
            end
            rsp_pkg::B_ROUND:     state_next = rsp_pkg::B_OFF_C;
            rsp_pkg::B_OFF_C:     state_next = rsp_pkg::B_OFF_S;
            rsp_pkg::B_OFF_S:     state_next = rsp_pkg::B_XY;
            rsp_pkg::B_XY:        state_next = rsp_pkg::B_POINT;
            rsp_pkg::B_POINT:
            begin
                if (out_free)
                begin
                    state_next = item_reg.last_beam ? rsp_pkg::B_DIV_START : rsp_pkg::B_IDLE;
                end
            end
            rsp_pkg::B_DIV_START:
            begin
                state_next = (kept_count_reg == '0) ? rsp_pkg::B_SUMMARY : rsp_pkg::B_DIV_WAIT;
            end
            rsp_pkg::B_DIV_WAIT:  if (div_x_status.done) state_next = rsp_pkg::B_SUMMARY;
            rsp_pkg::B_SUMMARY:   if (out_free) state_next = rsp_pkg::B_IDLE;
            default:              state_next = rsp_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            rsp_pkg::B_IDLE:      pop = !queue_empty;
            rsp_pkg::B_POINT:     out_load = out_free;
            rsp_pkg::B_SUMMARY:   out_load = out_free;
            rsp_pkg::B_DIV_START: div_start = (kept_count_reg != '0);
            default:
            begin
                pop       = 1'b0;
                out_load  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    rsp_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (sum_x_reg),
        .den    (kept_count_reg),
        .status (div_x_status),
        .quot   (quot_x)
    );

    rsp_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (sum_y_reg),
        .den    (kept_count_reg),
        .status (div_y_status),
        .quot   (quot_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rsp_pkg::B_IDLE;
            out_valid_reg  <= 1'b0;
            kept_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && pop_item.first)
            begin
                kept_count_reg <= '0;
            end
            else if (out_load && state_reg == rsp_pkg::B_POINT && item_reg.kept &&
                     kept_count_reg < CNT_W'(MAX_READINGS))
            begin
                kept_count_reg <= kept_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rsp_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    item_reg <= pop_item;
                    if (pop_item.first)
                    begin
                        box_lx_reg <= pose_x;
                        box_hx_reg <= pose_x;
                        box_ly_reg <= pose_y;
                        box_hy_reg <= pose_y;
                        sum_x_reg  <= '0;
                        sum_y_reg  <= '0;
                    end
                end
            end
            rsp_pkg::B_X:
            begin
                x_reg    <= prod[46:15];
                t_reg    <= prod[46:15];
                s_reg    <= $signed(prod[46:15]);
                c_reg    <= $signed(rsp_pkg::ONE_Q30);
                term_reg <= '0;
            end
            rsp_pkg::B_X2:   x2_reg <= prod[61:30];
            rsp_pkg::B_TMUL: p_reg  <= prod[61:30];
            rsp_pkg::B_TDIV: q_reg  <= prod[63:32];
            rsp_pkg::B_TFIX:
            begin
                // terms alternate in sign, starting with a subtraction
                if (term_reg < rsp_pkg::SIN_TERMS)
                begin
                    s_reg <= term_reg[0] ? s_reg + $signed(qf) : s_reg - $signed(qf);
                end
                else
                begin
                    c_reg <= term_reg[0] ? c_reg + $signed(qf) : c_reg - $signed(qf);
                end
                t_reg    <= (term_reg == rsp_pkg::SIN_TERMS - 1'b1) ? rsp_pkg::ONE_Q30 : qf;
                term_reg <= term_reg + 1'b1;
            end
            rsp_pkg::B_ROUND:
            begin
                case (item_reg.beam_angle[15:14])
                    2'd0:
                    begin
                        co_mag_reg <= cos_rnd[MAG_W-1:0];
                        co_neg_reg <= 1'b0;
                        si_mag_reg <= sin_rnd[MAG_W-1:0];
                        si_neg_reg <= 1'b0;
                    end
                    2'd1:
                    begin
                        co_mag_reg <= sin_rnd[MAG_W-1:0];
                        co_neg_reg <= 1'b1;
                        si_mag_reg <= cos_rnd[MAG_W-1:0];
                        si_neg_reg <= 1'b0;
                    end
                    2'd2:
                    begin
                        co_mag_reg <= cos_rnd[MAG_W-1:0];
                        co_neg_reg <= 1'b1;
                        si_mag_reg <= sin_rnd[MAG_W-1:0];
                        si_neg_reg <= 1'b1;
                    end
                    default:
                    begin
                        co_mag_reg <= sin_rnd[MAG_W-1:0];
                        co_neg_reg <= 1'b0;
                        si_mag_reg <= cos_rnd[MAG_W-1:0];
                        si_neg_reg <= 1'b1;
                    end
                endcase
            end
            rsp_pkg::B_OFF_C: off_c_reg <= off_full[OFF_W-1:0];
            rsp_pkg::B_OFF_S: off_s_reg <= off_full[OFF_W-1:0];
            rsp_pkg::B_XY:
            begin
                x_pt_reg <= place(pose_x, off_c_reg, co_neg_reg);
                y_pt_reg <= place(pose_y, off_s_reg, si_neg_reg);
            end
            rsp_pkg::B_POINT:
            begin
                if (out_load)
                begin
                    out_item_reg             <= '0;
                    out_item_reg.result_kind <= rsp_pkg::RESULT_POINT;
                    out_item_reg.x_mm        <= x_pt_reg;
                    out_item_reg.y_mm        <= y_pt_reg;
                    out_item_reg.point_kept  <= item_reg.kept;
                    if (item_reg.kept)
                    begin
                        if (x_pt_reg < box_lx_reg) box_lx_reg <= x_pt_reg;
                        if (x_pt_reg > box_hx_reg) box_hx_reg <= x_pt_reg;
                        if (y_pt_reg < box_ly_reg) box_ly_reg <= y_pt_reg;
                        if (y_pt_reg > box_hy_reg) box_hy_reg <= y_pt_reg;
                        if (kept_count_reg < CNT_W'(MAX_READINGS))
                        begin
                            sum_x_reg <= sum_x_reg + SUM_W'(x_pt_reg);
                            sum_y_reg <= sum_y_reg + SUM_W'(y_pt_reg);
                        end
                    end
                end
            end
            rsp_pkg::B_SUMMARY:
            begin
                if (out_load)
                begin
                    out_item_reg             <= '0;
                    out_item_reg.result_kind <= rsp_pkg::RESULT_SUMMARY;
                    out_item_reg.box_min_x   <= box_lx_reg;
                    out_item_reg.box_min_y   <= box_ly_reg;
                    out_item_reg.box_max_x   <= box_hx_reg;
                    out_item_reg.box_max_y   <= box_hy_reg;
                    // a scan with no kept readings falls back to the pose
                    out_item_reg.center_x    <= (kept_count_reg == '0) ? pose_x
                                                : quot_x[rsp_pkg::COORD_W-1:0];
                    out_item_reg.center_y    <= (kept_count_reg == '0) ? pose_y
                                                : quot_y[rsp_pkg::COORD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    `RSP_ASSERT_IMPLIES(a_div_running, clk, rst_n, state_reg == rsp_pkg::B_DIV_WAIT, div_x_status.busy || div_x_status.done)
    `RSP_ASSERT_IMPLIES(a_div_lockstep, clk, rst_n, div_x_status.done, div_y_status.done)
    `RSP_ASSERT_IMPLIES(a_summary_on_last, clk, rst_n, out_load && state_reg == rsp_pkg::B_SUMMARY, item_reg.last_beam)
    `RSP_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, kept_count_reg <= CNT_W'(MAX_READINGS))

endmodule
